// File: hdl/weno_pkg.sv
package weno_pkg;

    // Fixed widths of the smoothness path, which always works on Q1.14 values.
    localparam int Q14_W  = 16;
    localparam int DIFF_W = 20;
    localparam int SQ_W   = 37;
    localparam int B_W    = 39;
    localparam int IND_W  = 44;
    localparam int EPS_W  = 16;

    localparam logic [EPS_W-1:0] EPS_RESET = 16'd4295;

    localparam int NUM_LANES = 3;

    // Second and first differences of each stencil, and its candidate value times six.
    localparam int K_DIFF1 [3]    = '{1, -2, 1};
    localparam int K_DIFF2 [3][3] = '{'{1, -4, 3}, '{1, 0, -1}, '{3, -4, 1}};
    localparam int K_CAND  [3][3] = '{'{2, -7, 11}, '{-1, 5, 2}, '{2, 5, -1}};

    // Linear weights 1/10, 3/5 and 3/10 scaled by ten.
    localparam int K_GAMMA [3] = '{1, 6, 3};

    typedef struct packed {
        logic adv;
        logic vld;
    } t_flow;

endpackage

// File: hdl/weno_ifs.sv
interface weno_stencil_if #(parameter int SAMPLE_WIDTH = 16);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_m2;
    logic signed [SAMPLE_WIDTH-1:0] sample_m1;
    logic signed [SAMPLE_WIDTH-1:0] sample_c;
    logic signed [SAMPLE_WIDTH-1:0] sample_p1;
    logic signed [SAMPLE_WIDTH-1:0] sample_p2;

    modport source (output valid, sample_m2, sample_m1, sample_c, sample_p1, sample_p2,
                    input ready);
    modport sink (input valid, sample_m2, sample_m1, sample_c, sample_p1, sample_p2,
                  output ready);
endinterface

interface weno_face_if #(parameter int SAMPLE_WIDTH = 16);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] face_value;

    modport source (output valid, face_value, input ready);
    modport sink (input valid, face_value, output ready);
endinterface

interface weno_cfg_if import weno_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [EPS_W-1:0] smoothness_epsilon;

    modport source (output valid, smoothness_epsilon, input ready);
    modport sink (input valid, smoothness_epsilon, output ready);
endinterface

// File: hdl/weno5_face_reconstruction.sv
// Fifth-order WENO reconstruction of the left state at the face between the
// centre cell and its right neighbour, with Jiang-Shu smoothness indicators.
// Each request carries a five-cell stencil of signed samples with two integer
// bits; one face value in the same format comes back per request, in order,
// rounded to nearest with ties away from zero and saturated to the sample
// range. The block is fully pipelined and takes one request every clock
// cycle unless a result waits in the output register and the consumer
// does not take it. A request passes through the stencil lanes, the register
// that holds the smallest indicator, the bit-per-stage weight dividers, the
// stages that form the weighted sums, the final bit-per-stage divider and
// the output register. The weight ratios carry WEIGHT_BITS fraction bits,
// (54 - SAMPLE_WIDTH) / 2 capped at 16. When the consumer holds off, the
// whole pipeline freezes; while the output register is empty, a new request
// is taken regardless of the consumer. The epsilon register may be written
// at any time the block is idle and is ready at once.
module weno5_face_reconstruction import weno_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    weno_stencil_if.sink       i_stencil,
    weno_face_if.source        o_face,
    weno_cfg_if.sink           i_cfg
);

    localparam int WEIGHT_BITS = (((54 - SAMPLE_WIDTH) / 2) > 16) ? 16
                                                                  : (54 - SAMPLE_WIDTH) / 2;
    localparam int CAND_W = SAMPLE_WIDTH + 5;
    localparam int QUO_W  = SAMPLE_WIDTH + 2;
    localparam int RNUM_W = IND_W + WEIGHT_BITS;

    localparam logic [QUO_W-1:0] SAT_HI = {3'b000, {(SAMPLE_WIDTH - 1){1'b1}}};

    logic                    w_adv;
    t_flow                   w_flow;
    logic [EPS_W-1:0]        r_eps;

    logic signed [SAMPLE_WIDTH-1:0] w_smp [0:4];
    logic                    w_lane_vld [3];
    logic [IND_W-1:0]        w_ind [3];
    logic signed [CAND_W-1:0] w_cand [3];

    logic                    r_mvld;
    logic [IND_W-1:0]        r_ind [3];
    logic signed [CAND_W-1:0] r_cand [3];
    logic                    r_dz [3];
    logic [IND_W-1:0]        n_dmin, r_dmin;

    logic                    w_div_vld [3];
    logic [WEIGHT_BITS:0]    w_quo [3];
    logic [CAND_W:0]         w_tag [3];
    logic [WEIGHT_BITS:0]    w_ratio [3];
    logic signed [CAND_W-1:0] w_rcand [3];

    logic                    w_mvld;
    logic [QUO_W-1:0]        w_mquo;
    logic                    w_mneg;

    logic signed [SAMPLE_WIDTH-1:0] n_face, r_face;
    logic                    r_out_vld;

    // The whole pipeline moves together; it only stops when a result sits in
    // the output register and the consumer does not take it.
    assign w_adv  = !r_out_vld || o_face.ready;
    assign w_flow = '{adv: w_adv, vld: i_stencil.valid};

    assign i_stencil.ready = w_adv;

    // Epsilon register: always ready.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (i_cfg.valid) begin
            r_eps <= i_cfg.smoothness_epsilon;
        end
    end

    assign w_smp[0] = i_stencil.sample_m2;
    assign w_smp[1] = i_stencil.sample_m1;
    assign w_smp[2] = i_stencil.sample_c;
    assign w_smp[3] = i_stencil.sample_p1;
    assign w_smp[4] = i_stencil.sample_p2;

    // Three lanes, one for each three-cell sub-stencil. Each forms its
    // smoothness indicator (as eps plus beta, on a common scale) and its
    // third-order candidate held as six times its value.
    for (genvar j = 0; j < NUM_LANES; j++) begin : g_lane
        weno_lane #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .LANE         (j)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_flow  (w_flow),
            .i_smp   (w_smp[j:j+2]),
            .i_eps   (r_eps),
            .o_vld   (w_lane_vld[j]),
            .o_ind   (w_ind[j]),
            .o_cand  (w_cand[j])
        );
    end

    // The smallest indicator becomes the reference so that the smoothest
    // stencil gets a ratio of exactly one.
    always_comb begin
        n_dmin = w_ind[0];
        if (w_ind[1] < n_dmin) begin
            n_dmin = w_ind[1];
        end
        if (w_ind[2] < n_dmin) begin
            n_dmin = w_ind[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvld <= 1'b0;
        end else if (w_adv) begin
            r_mvld <= w_lane_vld[0] & w_lane_vld[1] & w_lane_vld[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dmin <= n_dmin;
            for (int j = 0; j < NUM_LANES; j++) begin
                r_ind[j]  <= w_ind[j];
                r_cand[j] <= w_cand[j];
                r_dz[j]   <= w_ind[j] == '0;
            end
        end
    end

    // Per-lane ratio of the smallest indicator to this lane's one. A lane
    // whose indicator is zero (only possible with a zero epsilon) takes the
    // full weight; the divider then leaves the other zero-free lanes at zero.
    for (genvar j = 0; j < NUM_LANES; j++) begin : g_ratio
        weno_div #(
            .NUM_W (RNUM_W),
            .DEN_W (IND_W),
            .QUO_W (WEIGHT_BITS + 1),
            .TAG_W (CAND_W + 1)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_flow  ('{adv: w_adv, vld: r_mvld}),
            .i_num   ({r_dmin, {WEIGHT_BITS{1'b0}}}),
            .i_den   (r_ind[j]),
            .i_tag   ({r_dz[j], r_cand[j]}),
            .o_vld   (w_div_vld[j]),
            .o_quo   (w_quo[j]),
            .o_tag   (w_tag[j])
        );

        assign w_rcand[j] = w_tag[j][CAND_W-1:0];
        assign w_ratio[j] = w_tag[j][CAND_W] ? (WEIGHT_BITS + 1)'(1) << WEIGHT_BITS
                                             : w_quo[j];
    end

    // Nonlinear weights, weighted sum and the final normalising division.
    weno_merge #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flow  ('{adv: w_adv, vld: w_div_vld[0] & w_div_vld[1] & w_div_vld[2]}),
        .i_ratio (w_ratio),
        .i_cand  (w_rcand),
        .o_vld   (w_mvld),
        .o_quo   (w_mquo),
        .o_neg   (w_mneg)
    );

    // Apply the sign and saturate to the sample range.
    always_comb begin
        if (w_mneg) begin
            if (w_mquo > SAT_HI + QUO_W'(1)) begin
                n_face = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
            end else begin
                n_face = SAMPLE_WIDTH'(QUO_W'(~w_mquo + QUO_W'(1)));
            end
        end else begin
            if (w_mquo > SAT_HI) begin
                n_face = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
            end else begin
                n_face = SAMPLE_WIDTH'(w_mquo);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_mvld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_face <= n_face;
        end
    end

    assign o_face.valid      = r_out_vld;
    assign o_face.face_value = r_face;

endmodule

// File: hdl/weno_div.sv
module weno_div import weno_pkg::*; #(
    parameter int NUM_W = 60,
    parameter int DEN_W = 44,
    parameter int QUO_W = 17,
    parameter int TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_flow            i_flow,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_vld,
    output logic [QUO_W-1:0] o_quo,
    output logic [TAG_W-1:0] o_tag
);

    // One quotient bit per stage, most significant first.
    localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [NUM_W-1:0] r_rem [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];
    logic [TAG_W-1:0] r_tag [QUO_W];
    logic             r_vld [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic [TAG_W-1:0] tag_in;
        logic             vld_in;
        logic [CMP_W-1:0] shifted;
        logic             take;
        logic [NUM_W-1:0] n_rem;
        logic [QUO_W-1:0] n_quo;

        if (k == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
            assign tag_in = i_tag;
            assign vld_in = i_flow.vld;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign quo_in = r_quo[k-1];
            assign tag_in = r_tag[k-1];
            assign vld_in = r_vld[k-1];
        end

        always_comb begin
            shifted = CMP_W'(den_in) << (QUO_W - 1 - k);
            take    = CMP_W'(rem_in) >= shifted;
            n_rem   = take ? NUM_W'(CMP_W'(rem_in) - shifted) : rem_in;
            n_quo   = quo_in;
            n_quo[QUO_W-1-k] = take;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_flow.adv) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_flow.adv) begin
                r_rem[k] <= n_rem;
                r_den[k] <= den_in;
                r_quo[k] <= n_quo;
                r_tag[k] <= tag_in;
            end
        end
    end

    assign o_vld = r_vld[QUO_W-1];
    assign o_quo = r_quo[QUO_W-1];
    assign o_tag = r_tag[QUO_W-1];

endmodule

// File: hdl/weno_lane.sv
module weno_lane import weno_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int LANE         = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_flow                          i_flow,
    input  logic signed [SAMPLE_WIDTH-1:0] i_smp [0:2],
    input  logic [EPS_W-1:0]               i_eps,
    output logic                           o_vld,
    output logic [IND_W-1:0]               o_ind,
    output logic signed [SAMPLE_WIDTH+4:0] o_cand
);

    localparam int CAND_W = SAMPLE_WIDTH + 5;

    logic signed [DIFF_W-1:0] w_q [3];

    logic signed [DIFF_W-1:0] n_e1, n_e2, r_e1, r_e2;
    logic signed [CAND_W-1:0] n_u, r_u1, r_u2, r_u3;
    logic signed [2*DIFF_W-1:0] w_p1, w_p2;
    logic [SQ_W-1:0]  r_sq1, r_sq2;
    logic [B_W-1:0]   w_b;
    logic [IND_W-1:0] n_ind, r_ind;
    logic             r_v [3];

    // Samples brought to Q1.14: wider ones floor-shifted, narrower ones scaled up.
    for (genvar j = 0; j < 3; j++) begin : g_q14
        if (SAMPLE_WIDTH >= Q14_W) begin : g_down
            assign w_q[j] = DIFF_W'(i_smp[j] >>> (SAMPLE_WIDTH - Q14_W));
        end else begin : g_up
            assign w_q[j] = DIFF_W'(i_smp[j]) <<< (Q14_W - SAMPLE_WIDTH);
        end
    end

    always_comb begin
        n_e1 = '0;
        n_e2 = '0;
        n_u  = '0;
        for (int j = 0; j < 3; j++) begin
            n_e1 = n_e1 + DIFF_W'(K_DIFF1[j]) * w_q[j];
            n_e2 = n_e2 + DIFF_W'(K_DIFF2[LANE][j]) * w_q[j];
            n_u  = n_u + CAND_W'(K_CAND[LANE][j]) * CAND_W'(i_smp[j]);
        end
    end

    assign w_p1  = r_e1 * r_e1;
    assign w_p2  = r_e2 * r_e2;
    assign w_b   = B_W'(r_sq1) * B_W'(13) + B_W'(r_sq2) * B_W'(3);
    assign n_ind = {w_b, 4'b0000} + IND_W'(i_eps) * IND_W'(12);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
            r_v[1] <= 1'b0;
            r_v[2] <= 1'b0;
        end else if (i_flow.adv) begin
            r_v[0] <= i_flow.vld;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_flow.adv) begin
            r_e1  <= n_e1;
            r_e2  <= n_e2;
            r_u1  <= n_u;
            r_sq1 <= SQ_W'(w_p1);
            r_sq2 <= SQ_W'(w_p2);
            r_u2  <= r_u1;
            r_ind <= n_ind;
            r_u3  <= r_u2;
        end
    end

    assign o_vld  = r_v[2];
    assign o_ind  = r_ind;
    assign o_cand = r_u3;

endmodule

// File: hdl/weno_merge.sv
module weno_merge import weno_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_flow                          i_flow,
    input  logic [WEIGHT_BITS:0]           i_ratio [3],
    input  logic signed [SAMPLE_WIDTH+4:0] i_cand [3],
    output logic                           o_vld,
    output logic [SAMPLE_WIDTH+1:0]        o_quo,
    output logic                           o_neg
);

    localparam int RSQ_W  = 2 * WEIGHT_BITS + 1;
    localparam int GU_W   = SAMPLE_WIDTH + 7;
    localparam int PR_W   = RSQ_W + 1 + GU_W;
    localparam int NUM_W  = 2 * WEIGHT_BITS + SAMPLE_WIDTH + 7;
    localparam int DEN_W  = 2 * WEIGHT_BITS + 4;
    localparam int DIV_W  = 2 * WEIGHT_BITS + 7;
    localparam int QUO_W  = SAMPLE_WIDTH + 2;

    logic [RSQ_W-1:0]        r_rsq [3];
    logic signed [GU_W-1:0]  r_gu [3];
    logic signed [PR_W-1:0]  w_prod [3];
    logic signed [NUM_W-1:0] r_prod [3];
    logic [DEN_W-1:0]        n_den, r_den2, r_den3;
    logic signed [NUM_W-1:0] r_num;
    logic                    w_neg;
    logic [NUM_W-1:0]        w_mag;
    logic [NUM_W-1:0]        r_dvd;
    logic [DIV_W-1:0]        r_dvs;
    logic                    r_neg;
    logic                    r_v [4];

    for (genvar j = 0; j < 3; j++) begin : g_prod
        assign w_prod[j] = $signed({1'b0, r_rsq[j]}) * r_gu[j];
    end

    always_comb begin
        n_den = '0;
        for (int j = 0; j < 3; j++) begin
            n_den = n_den + DEN_W'(r_rsq[j]) * DEN_W'(K_GAMMA[j]);
        end
    end

    assign w_neg = r_num < 0;
    assign w_mag = w_neg ? NUM_W'(-r_num) : NUM_W'(r_num);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 4; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (i_flow.adv) begin
            r_v[0] <= i_flow.vld;
            for (int s = 1; s < 4; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_flow.adv) begin
            for (int j = 0; j < 3; j++) begin
                r_rsq[j]  <= RSQ_W'(i_ratio[j]) * RSQ_W'(i_ratio[j]);
                r_gu[j]   <= GU_W'(i_cand[j]) * GU_W'(K_GAMMA[j]);
                r_prod[j] <= NUM_W'(w_prod[j]);
            end
            r_den2 <= n_den;
            r_num  <= r_prod[0] + r_prod[1] + r_prod[2];
            r_den3 <= r_den2;
            r_neg  <= w_neg;
            r_dvd  <= w_mag + NUM_W'(r_den3) * NUM_W'(3);
            r_dvs  <= DIV_W'(r_den3) * DIV_W'(6);
        end
    end

    weno_div #(
        .NUM_W (NUM_W),
        .DEN_W (DIV_W),
        .QUO_W (QUO_W),
        .TAG_W (1)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flow  ('{adv: i_flow.adv, vld: r_v[3]}),
        .i_num   (r_dvd),
        .i_den   (r_dvs),
        .i_tag   (r_neg),
        .o_vld   (o_vld),
        .o_quo   (o_quo),
        .o_tag   (o_neg)
    );

endmodule

// File: tb/tb_weno5_face_reconstruction.sv
module tb_weno5_face_reconstruction;
    import weno_pkg::*;

    // The default sample width gives Q1.14 samples and 16 weight bits.
    localparam int SW           = 16;
    localparam int WBITS        = 16;
    // Pipeline depth of the block under test, plus some margin.
    localparam int PIPE_LATENCY = SW + WBITS + 12;
    localparam int SETTLE       = PIPE_LATENCY + 8;
    // Cycles with no handshake on any channel before the run is abandoned.
    localparam int STALL_LIMIT  = 3000;
    localparam int LONG_HOLD    = 300;

    typedef logic signed [SW-1:0] t_sample;

    typedef struct {
        t_sample m2;
        t_sample m1;
        t_sample c;
        t_sample p1;
        t_sample p2;
    } t_stencil;

    logic i_clk;
    logic i_rst_n;

    weno_stencil_if #(.SAMPLE_WIDTH(SW)) stencil_ch ();
    weno_face_if #(.SAMPLE_WIDTH(SW))    face_ch ();
    weno_cfg_if                          cfg_ch ();

    weno5_face_reconstruction #(.SAMPLE_WIDTH(SW)) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_stencil (stencil_ch.sink),
        .o_face    (face_ch.source),
        .i_cfg     (cfg_ch.sink)
    );

    // Our own copy of the epsilon register, and the face values still owed.
    logic [EPS_W-1:0] model_epsilon;
    t_sample          pending_faces[$];
    int               error_count;
    int               idle_cycles;
    bit               sender_gaps;
    bit               receiver_gaps;
    int               hold_request;

    // The clock runs with a period of 20 units.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Scaled smoothness indicator: 16 * 12 * beta + 12 * eps, all exact.
    function automatic longint unsigned smoothness(longint d1, longint d2,
                                                   longint unsigned eps);
        return 16 * (13 * longint'(d1 * d1) + 3 * longint'(d2 * d2)) + 12 * eps;
    endfunction

    // Weight ratio relative to the smoothest stencil; a zero indicator wins
    // outright, which is how the weights behave as epsilon goes to zero.
    function automatic longint unsigned weight_ratio(longint unsigned dmin,
                                                     longint unsigned d);
        if (d == 0) begin
            return longint'(1) << WBITS;
        end
        if (dmin == 0) begin
            return 0;
        end
        return (dmin << WBITS) / d;
    endfunction

    function automatic t_sample reconstruct_face(t_stencil s, logic [EPS_W-1:0] eps_reg);
        longint          m2, m1, c, p1, p2;
        longint unsigned eps, ind1, ind2, ind3, dmin, r1, r2, r3;
        longint          a1, a2, a3, u1, u2, u3, num;
        longint unsigned den, mag, quot;
        bit              neg;
        m2  = s.m2;
        m1  = s.m1;
        c   = s.c;
        p1  = s.p1;
        p2  = s.p2;
        eps = eps_reg;
        ind1 = smoothness(m2 - 2 * m1 + c, m2 - 4 * m1 + 3 * c, eps);
        ind2 = smoothness(m1 - 2 * c + p1, m1 - p1, eps);
        ind3 = smoothness(c - 2 * p1 + p2, 3 * c - 4 * p1 + p2, eps);
        dmin = ind1;
        if (ind2 < dmin) begin
            dmin = ind2;
        end
        if (ind3 < dmin) begin
            dmin = ind3;
        end
        r1 = weight_ratio(dmin, ind1);
        r2 = weight_ratio(dmin, ind2);
        r3 = weight_ratio(dmin, ind3);
        a1 = r1 * r1;
        a2 = 6 * r2 * r2;
        a3 = 3 * r3 * r3;
        // Candidate values held as six times the third-order estimates.
        u1  = 2 * m2 - 7 * m1 + 11 * c;
        u2  = -m1 + 5 * c + 2 * p1;
        u3  = 2 * c + 5 * p1 - p2;
        num = a1 * u1 + a2 * u2 + a3 * u3;
        den = a1 + a2 + a3;
        neg = num < 0;
        mag = neg ? -num : num;
        // Round half away from zero, then clip to the sample range.
        quot = (mag + 3 * den) / (6 * den);
        if (neg) begin
            return (quot > 32768) ? t_sample'(-32768) : t_sample'(-longint'(quot));
        end
        return (quot > 32767) ? t_sample'(32767) : t_sample'(quot);
    endfunction

    function automatic t_sample clip_sample(longint v);
        if (v > 32767) begin
            return t_sample'(32767);
        end
        if (v < -32768) begin
            return t_sample'(-32768);
        end
        return t_sample'(v);
    endfunction

    // Sends one stencil request and records the face value it must produce.
    task automatic send_stencil(t_stencil s);
        int gap;
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            stencil_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        stencil_ch.valid     = 1'b1;
        stencil_ch.sample_m2 = s.m2;
        stencil_ch.sample_m1 = s.m1;
        stencil_ch.sample_c  = s.c;
        stencil_ch.sample_p1 = s.p1;
        stencil_ch.sample_p2 = s.p2;
        do begin
            @(posedge i_clk);
        end while (!stencil_ch.ready);
        pending_faces.push_back(reconstruct_face(s, model_epsilon));
        @(negedge i_clk);
    endtask

    task automatic stop_sending();
        stencil_ch.valid = 1'b0;
    endtask

    task automatic send_samples(int m2, int m1, int c, int p1, int p2);
        t_stencil s;
        s.m2 = t_sample'(m2);
        s.m1 = t_sample'(m1);
        s.c  = t_sample'(c);
        s.p1 = t_sample'(p1);
        s.p2 = t_sample'(p2);
        send_stencil(s);
    endtask

    // Waits for the pipeline to drain, then writes epsilon.
    task automatic write_epsilon(logic [EPS_W-1:0] value);
        stop_sending();
        wait (pending_faces.size() == 0);
        repeat (SETTLE) @(negedge i_clk);
        cfg_ch.valid              = 1'b1;
        cfg_ch.smoothness_epsilon = value;
        do begin
            @(posedge i_clk);
        end while (!cfg_ch.ready);
        model_epsilon = value;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Random stencil: half smooth data, the rest shocks, raw noise and extremes.
    function automatic t_stencil random_stencil();
        t_stencil s;
        int       mode, base, slope, curv, lo, hi, jump;
        mode  = $urandom_range(0, 9);
        base  = $urandom_range(0, 65535) - 32768;
        slope = $urandom_range(0, 2047) - 1024;
        curv  = $urandom_range(0, 127) - 64;
        if (mode <= 4) begin
            s.m2 = clip_sample(base - 2 * slope + 4 * curv);
            s.m1 = clip_sample(base - slope + curv);
            s.c  = clip_sample(base);
            s.p1 = clip_sample(base + slope + curv);
            s.p2 = clip_sample(base + 2 * slope + 4 * curv);
        end else if (mode <= 6) begin
            lo   = $urandom_range(0, 65535) - 32768;
            hi   = $urandom_range(0, 65535) - 32768;
            jump = $urandom_range(0, 4);
            s.m2 = t_sample'((jump > 0) ? lo : hi);
            s.m1 = t_sample'((jump > 1) ? lo : hi);
            s.c  = t_sample'((jump > 2) ? lo : hi);
            s.p1 = t_sample'((jump > 3) ? lo : hi);
            s.p2 = t_sample'(hi);
        end else if (mode <= 8) begin
            s.m2 = t_sample'($urandom());
            s.m1 = t_sample'($urandom());
            s.c  = t_sample'($urandom());
            s.p1 = t_sample'($urandom());
            s.p2 = t_sample'($urandom());
        end else begin
            s.m2 = t_sample'($urandom_range(0, 1) ? 32767 : -32768);
            s.m1 = t_sample'($urandom_range(0, 1) ? 32767 : -32768);
            s.c  = t_sample'($urandom_range(0, 1) ? 32767 : -32768);
            s.p1 = t_sample'($urandom_range(0, 1) ? 32767 : -32768);
            s.p2 = t_sample'($urandom_range(0, 1) ? 32767 : -32768);
        end
        return s;
    endfunction

    // The receiver stalls in random bursts, or for one long stretch on request.
    always @(negedge i_clk) begin : face_receiver
        int stall_left;
        if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
        end
        if (stall_left > 0) begin
            face_ch.ready = 1'b0;
            stall_left    = stall_left - 1;
        end else if (receiver_gaps && $urandom_range(0, 3) == 0) begin
            face_ch.ready = 1'b0;
            stall_left    = $urandom_range(0, 11);
        end else begin
            face_ch.ready = 1'b1;
        end
    end

    // Every face value that leaves the block is compared with the oldest owed.
    always @(posedge i_clk) begin : face_checker
        t_sample want;
        if (i_rst_n && face_ch.valid && face_ch.ready) begin
            if (pending_faces.size() == 0) begin
                $error("face_value: none expected, actual %0d", face_ch.face_value);
                error_count++;
            end else begin
                want = pending_faces.pop_front();
                if (face_ch.face_value !== want) begin
                    $error("face_value: expected %0d, actual %0d", want, face_ch.face_value);
                    error_count++;
                end
            end
        end
    end

    // The watchdog counts cycles in which no request moves on any channel.
    always @(posedge i_clk) begin : watchdog
        if ((stencil_ch.valid && stencil_ch.ready) || (face_ch.valid && face_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL weno5_face_reconstruction");
            $finish;
        end
    end

    // Extremes of every sample, flat stencils and the saturating corners.
    task automatic test_extremes();
        send_samples(0, 0, 0, 0, 0);
        send_samples(32767, 32767, 32767, 32767, 32767);
        send_samples(-32768, -32768, -32768, -32768, -32768);
        send_samples(-32768, 32767, -32768, 32767, -32768);
        send_samples(32767, -32768, 32767, -32768, 32767);
        send_samples(32767, -32768, 32767, 32767, 32767);
        send_samples(-32768, 32767, -32768, -32768, -32768);
        send_samples(0, 0, 32767, 32767, -32768);
        send_samples(0, 0, -32768, -32768, 32767);
        send_samples(-1, -1, -1, -1, -1);
        send_samples(1, -1, 1, -1, 1);
        send_samples(-32768, -16384, 0, 16384, 32767);
        send_samples(0, 0, 0, 32767, 32767);
        send_samples(1, 2, 3, 4, 5);
        stop_sending();
    endtask

    // With epsilon zero, a flat stencil has a zero indicator and takes all weight.
    task automatic test_zero_epsilon();
        write_epsilon('0);
        send_samples(0, 0, 0, 0, 0);
        send_samples(100, 100, 100, 5000, -3000);
        send_samples(-7000, 2000, 300, 300, 300);
        send_samples(1000, 2000, 3000, 4000, 5000);
        send_samples(32767, 32767, 32767, -32768, -32768);
        send_samples(5, 5, 5, 5, 5);
        repeat (30) send_stencil(random_stencil());
        stop_sending();
    endtask

    // Several epsilon settings, the extremes among them, each with random traffic.
    task automatic test_epsilon_sweep();
        logic [EPS_W-1:0] settings[5];
        settings = '{16'd1, 16'hFFFF, EPS_RESET, 16'h8000, 16'd37};
        foreach (settings[k]) begin
            write_epsilon(settings[k]);
            repeat (60) send_stencil(random_stencil());
        end
        stop_sending();
    endtask

    // Bulk random traffic with gaps on both sides and a random epsilon.
    task automatic test_random_traffic();
        write_epsilon(16'($urandom_range(1, 65535)));
        repeat (500) send_stencil(random_stencil());
        stop_sending();
    endtask

    // The receiver holds off for a long stretch while stencils keep coming,
    // so the pipeline fills and pushes back on the sender.
    task automatic test_backpressure();
        hold_request = LONG_HOLD;
        repeat (120) send_stencil(random_stencil());
        stop_sending();
    endtask

    // Back-to-back stream at full rate with no idling on either side.
    task automatic test_full_rate();
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        write_epsilon(EPS_RESET);
        repeat (100) send_stencil(random_stencil());
        stop_sending();
    endtask

    initial begin
        i_rst_n                   = 1'b0;
        stencil_ch.valid          = 1'b0;
        stencil_ch.sample_m2      = '0;
        stencil_ch.sample_m1      = '0;
        stencil_ch.sample_c       = '0;
        stencil_ch.sample_p1      = '0;
        stencil_ch.sample_p2      = '0;
        face_ch.ready             = 1'b0;
        cfg_ch.valid              = 1'b0;
        cfg_ch.smoothness_epsilon = '0;
        model_epsilon             = EPS_RESET;
        error_count               = 0;
        idle_cycles               = 0;
        hold_request              = 0;
        sender_gaps               = 1'b1;
        receiver_gaps             = 1'b1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_extremes();
        test_zero_epsilon();
        test_epsilon_sweep();
        test_random_traffic();
        test_backpressure();
        test_full_rate();

        wait (pending_faces.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS weno5_face_reconstruction");
        end else begin
            $display("FAIL weno5_face_reconstruction");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/weno_pkg.sv
hdl/weno_ifs.sv
hdl/weno_div.sv
hdl/weno_lane.sv
hdl/weno_merge.sv
hdl/weno5_face_reconstruction.sv
tb/tb_weno5_face_reconstruction.sv
